>>> rtl/min_depth_pyramid_builder_defines.svh
// assertion helpers for the pyramid builder rtl
`ifndef MIN_DEPTH_PYRAMID_BUILDER_DEFINES_SVH
`define MIN_DEPTH_PYRAMID_BUILDER_DEFINES_SVH

// same-cycle implication, checked out of reset
`define MDP_ASSERT_NOW(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define MDP_ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

>>> rtl/mdp_pkg.sv
package mdp_pkg;

  // frame geometry
  localparam int MAX_LOG_SIZE = 10;
  localparam int LVL_W        = 4;
  localparam int POS_W        = MAX_LOG_SIZE;
  localparam int LINE_AW      = MAX_LOG_SIZE;
  localparam int LINE_DEPTH   = 1 << LINE_AW;
  localparam int COORD_W      = 9;
  localparam int PIX_W        = 8;
  localparam int LEFT_DEPTH   = MAX_LOG_SIZE;

  localparam logic [LVL_W-1:0] LOG_SIZE_RESET = LVL_W'(8);

  // queue depths
  localparam int CMD_AW    = 1;
  localparam int CMD_DEPTH = 1 << CMD_AW;
  localparam int RES_AW    = 2;
  localparam int RES_DEPTH = 1 << RES_AW;

  // classified pixel handed from front to back
  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic [POS_W-1:0] x;
    logic [POS_W-1:0] y;
    logic [LVL_W-1:0] n;
  } cmd_t;

  // one pyramid result
  typedef struct packed {
    logic [LVL_W-1:0]   level;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic [PIX_W-1:0]   min_value;
    logic               last;
  } res_t;

endpackage

>>> rtl/min_depth_pyramid_builder.sv
// channel   direction  handshake           beat contents
// in_       input      in_valid/in_stall   in_pixel
// out_      output     out_valid/out_stall out_level out_col out_row out_min_value out_last
// cfg_      input      cfg_wr_en           cfg_wr_data (log2 of image side)
//
// a pixel that closes no 2x2 block takes a queue pop and a level step
// each level a pixel closes adds a read state, set by the registered read of the
// pair-min line memory, where a full result queue can stall it; after the last
// result the walk takes a further level step unless the cascade reaches the top level
// reset clears control, position and log size (8); line store is not cleared
// input stalls when the 2-beat command queue fills; a 4-beat result queue
// absorbs cascades while out_stall is held
module min_depth_pyramid_builder import mdp_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [LVL_W-1:0]   cfg_wr_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [PIX_W-1:0]   in_pixel,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [LVL_W-1:0]   out_level,
  output logic [COORD_W-1:0] out_col,
  output logic [COORD_W-1:0] out_row,
  output logic [PIX_W-1:0]   out_min_value,
  output logic               out_last
);

  logic cmd_push, cmd_full, cmd_valid, cmd_pop;
  cmd_t cmd_in, cmd_head;
  logic res_push, res_full;
  res_t res_in, res_head;

  // accept and classify
  mdp_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_pixel    (in_pixel),
    .cmd_push    (cmd_push),
    .cmd         (cmd_in),
    .cmd_full    (cmd_full)
  );

  // decoupling queue
  mdp_cmd_q u_cmd_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (cmd_push),
    .push_data (cmd_in),
    .full      (cmd_full),
    .pop       (cmd_pop),
    .valid     (cmd_valid),
    .head      (cmd_head)
  );

  // level walk
  mdp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd       (cmd_head),
    .cmd_pop   (cmd_pop),
    .res_push  (res_push),
    .res       (res_in),
    .res_full  (res_full)
  );

  // result queue
  mdp_res_q u_res_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_push),
    .push_data (res_in),
    .full      (res_full),
    .pop       (!out_stall),
    .valid     (out_valid),
    .head      (res_head)
  );

  assign out_level     = res_head.level;
  assign out_col       = res_head.col;
  assign out_row       = res_head.row;
  assign out_min_value = res_head.min_value;
  assign out_last      = res_head.last;

endmodule

>>> rtl/mdp_front.sv
module mdp_front import mdp_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic [LVL_W-1:0] cfg_wr_data,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [PIX_W-1:0] in_pixel,
  output logic             cmd_push,
  output cmd_t             cmd,
  input  logic             cmd_full
);

  logic [LVL_W-1:0] log_size_r;
  logic [POS_W-1:0] col_r, col_nxt;
  logic [POS_W-1:0] row_r, row_nxt;
  logic [LVL_W-1:0] n_used;
  logic [POS_W:0]   side;
  logic [POS_W-1:0] pos_mask;
  logic [POS_W-1:0] x;
  logic [POS_W-1:0] y;

  // clamp the side exponent into the supported range
  always_comb begin
    if (log_size_r == '0) begin
      n_used = LVL_W'(1);
    end else if (log_size_r > LVL_W'(MAX_LOG_SIZE)) begin
      n_used = LVL_W'(MAX_LOG_SIZE);
    end else begin
      n_used = log_size_r;
    end
  end

  assign side     = (POS_W+1)'(1) << n_used;
  assign pos_mask = POS_W'(side - (POS_W+1)'(1));
  assign x        = col_r & pos_mask;
  assign y        = row_r & pos_mask;

  // raster position of the following pixel
  always_comb begin
    col_nxt = x + POS_W'(1);
    row_nxt = y;
    if (x == pos_mask) begin
      col_nxt = '0;
      row_nxt = (y == pos_mask) ? '0 : y + POS_W'(1);
    end
  end

  assign in_stall  = cmd_full;
  assign cmd_push  = in_valid && !cmd_full;
  assign cmd.pixel = in_pixel;
  assign cmd.x     = x;
  assign cmd.y     = y;
  assign cmd.n     = n_used;

  // register write restarts the frame
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      log_size_r <= LOG_SIZE_RESET;
      col_r      <= '0;
      row_r      <= '0;
    end else if (cfg_wr_en) begin
      log_size_r <= cfg_wr_data;
      col_r      <= '0;
      row_r      <= '0;
    end else if (cmd_push) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

endmodule

>>> rtl/mdp_cmd_q.sv
module mdp_cmd_q import mdp_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_data,
  output logic full,
  input  logic pop,
  output logic valid,
  output cmd_t head
);

  cmd_t              ent_r [CMD_DEPTH];
  logic [CMD_AW-1:0] wp_r;
  logic [CMD_AW-1:0] rp_r;
  logic [CMD_AW:0]   cnt_r;

  assign full  = (cnt_r == (CMD_AW+1)'(CMD_DEPTH));
  assign valid = (cnt_r != '0);
  assign head  = ent_r[rp_r];

  // storage
  always_ff @(posedge clk) begin
    if (push && !full) begin
      ent_r[wp_r] <= push_data;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push && !full) begin
        wp_r <= wp_r + CMD_AW'(1);
      end
      if (pop && valid) begin
        rp_r <= rp_r + CMD_AW'(1);
      end
      if ((push && !full) && !(pop && valid)) begin
        cnt_r <= cnt_r + (CMD_AW+1)'(1);
      end else if (!(push && !full) && (pop && valid)) begin
        cnt_r <= cnt_r - (CMD_AW+1)'(1);
      end
    end
  end

endmodule

>>> rtl/mdp_back.sv
`include "min_depth_pyramid_builder_defines.svh"

module mdp_back import mdp_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic cmd_valid,
  input  cmd_t cmd,
  output logic cmd_pop,
  output logic res_push,
  output res_t res,
  input  logic res_full
);

  typedef enum logic [1:0] {
    S_LOAD,
    S_STEP,
    S_READ
  } state_t;

  state_t           state_r;
  logic [PIX_W-1:0] v_r;
  logic [POS_W-1:0] x_r;
  logic [POS_W-1:0] y_r;
  logic [LVL_W-1:0] n_r;
  logic [LVL_W-1:0] l_r;
  logic [PIX_W-1:0] pm_r;
  logic [PIX_W-1:0] rd_r;

  logic [PIX_W-1:0] line_mem [LINE_DEPTH];
  logic [PIX_W-1:0] left_r   [LEFT_DEPTH];

  logic [POS_W-1:0]   sx, sy, hx, hy;
  logic [POS_W:0]     side;
  logic [POS_W:0]     idx_full;
  logic [LINE_AW-1:0] line_addr;
  logic [PIX_W-1:0]   left_val;
  logic [PIX_W-1:0]   pm;
  logic [PIX_W-1:0]   v_new;
  logic [LVL_W:0]     l_inc;
  logic               more;
  logic               left_we;
  logic               line_we;
  logic               line_re;

  // position of the current block at level l_r
  assign sx = x_r >> l_r;
  assign sy = y_r >> l_r;
  assign hx = sx >> 1;
  assign hy = sy >> 1;

  // line offset of this level inside the packed pair-min store
  assign side      = (POS_W+1)'(1) << n_r;
  assign idx_full  = side - (side >> l_r) + (POS_W+1)'(hx);
  assign line_addr = idx_full[LINE_AW-1:0];

  assign left_val = left_r[l_r];
  assign pm       = (left_val < v_r) ? left_val : v_r;
  assign v_new    = (rd_r < pm_r) ? rd_r : pm_r;

  // another level closes on this pixel when both next bits are odd
  assign l_inc = {1'b0, l_r} + (LVL_W+1)'(1);
  assign more  = (l_inc < {1'b0, n_r}) && hx[0] && hy[0];

  assign cmd_pop  = (state_r == S_LOAD) && cmd_valid;
  assign left_we  = (state_r == S_STEP) && !sx[0];
  assign line_we  = (state_r == S_STEP) && sx[0] && !sy[0];
  assign line_re  = (state_r == S_STEP) && sx[0] && sy[0];
  assign res_push = (state_r == S_READ) && !res_full;

  assign res.level     = l_inc[LVL_W-1:0];
  assign res.col       = hx[COORD_W-1:0];
  assign res.row       = hy[COORD_W-1:0];
  assign res.min_value = v_new;
  assign res.last      = !more;

  // pair-min line store and pending left pixels
  always_ff @(posedge clk) begin
    if (line_we) begin
      line_mem[line_addr] <= pm;
    end
    if (line_re) begin
      rd_r <= line_mem[line_addr];
    end
    if (left_we) begin
      left_r[l_r] <= v_r;
    end
  end

  // level walk
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
    end else begin
      case (state_r)
        S_LOAD: begin
          if (cmd_valid) begin
            v_r     <= cmd.pixel;
            x_r     <= cmd.x;
            y_r     <= cmd.y;
            n_r     <= cmd.n;
            l_r     <= '0;
            state_r <= S_STEP;
          end
        end
        S_STEP: begin
          if (line_re) begin
            pm_r    <= pm;
            state_r <= S_READ;
          end else begin
            state_r <= S_LOAD;
          end
        end
        S_READ: begin
          if (res_push) begin
            v_r <= v_new;
            // the next level exists: it parks its left pixel or pair minimum, or closes a block
            if (l_inc < {1'b0, n_r}) begin
              l_r     <= l_inc[LVL_W-1:0];
              state_r <= S_STEP;
            end else begin
              state_r <= S_LOAD;
            end
          end
        end
        default: begin
          state_r <= S_LOAD;
        end
      endcase
    end
  end

  `MDP_ASSERT_NOW(a_level_in_frame, state_r == S_READ, l_r < n_r, "level walk past frame size")
  `MDP_ASSERT_NEXT(a_cascade_steps, res_push && !res.last, state_r == S_STEP && l_r == $past(l_r) + LVL_W'(1), "cascade did not advance one level")
  `MDP_ASSERT_NEXT(a_load_starts, cmd_pop, state_r == S_STEP && l_r == '0, "new pixel not started at level zero")

endmodule

>>> rtl/mdp_res_q.sv
module mdp_res_q import mdp_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  res_t push_data,
  output logic full,
  input  logic pop,
  output logic valid,
  output res_t head
);

  res_t              ent_r [RES_DEPTH];
  logic [RES_AW-1:0] wp_r;
  logic [RES_AW-1:0] rp_r;
  logic [RES_AW:0]   cnt_r;

  assign full  = (cnt_r == (RES_AW+1)'(RES_DEPTH));
  assign valid = (cnt_r != '0);
  assign head  = ent_r[rp_r];

  // storage
  always_ff @(posedge clk) begin
    if (push && !full) begin
      ent_r[wp_r] <= push_data;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push && !full) begin
        wp_r <= wp_r + RES_AW'(1);
      end
      if (pop && valid) begin
        rp_r <= rp_r + RES_AW'(1);
      end
      if ((push && !full) && !(pop && valid)) begin
        cnt_r <= cnt_r + (RES_AW+1)'(1);
      end else if (!(push && !full) && (pop && valid)) begin
        cnt_r <= cnt_r - (RES_AW+1)'(1);
      end
    end
  end

endmodule

>>> tb/tb_min_depth_pyramid_builder.sv
module tb_min_depth_pyramid_builder import mdp_pkg::*; ;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT  = 600000;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned RANDOM_ITEMS = 340;

  logic               clk;
  logic               rst_n         = 1'b0;
  logic               cfg_wr_en     = 1'b0;
  logic [LVL_W-1:0]   cfg_wr_data   = '0;
  logic               in_valid      = 1'b0;
  logic               in_stall;
  logic [PIX_W-1:0]   in_pixel      = '0;
  logic               out_valid;
  logic               out_stall     = 1'b0;
  logic [LVL_W-1:0]   out_level;
  logic [COORD_W-1:0] out_col;
  logic [COORD_W-1:0] out_row;
  logic [PIX_W-1:0]   out_min_value;
  logic               out_last;

  // pyramid state mirrored by the predictor
  logic [LVL_W-1:0] cur_log = LOG_SIZE_RESET;
  logic [PIX_W-1:0] line_mins [LINE_DEPTH];
  logic [PIX_W-1:0] left_px [LEFT_DEPTH];
  int unsigned      pos_x = 0;
  int unsigned      pos_y = 0;

  res_t        expected_mins [$];
  bit          failed = 1'b0;
  int unsigned cycle_count = 0;
  int unsigned pixels_sent = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  min_depth_pyramid_builder u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_pixel      (in_pixel),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_level     (out_level),
    .out_col       (out_col),
    .out_row       (out_row),
    .out_min_value (out_min_value),
    .out_last      (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // expected level pixels for one input beat, cascade in increasing level order
  task automatic pyramid_predict(input logic [PIX_W-1:0] px);
    int unsigned lg, side, x, y, sx, sy, idx, l, count;
    logic [PIX_W-1:0] v, pm;
    res_t r;
    res_t cascade [MAX_LOG_SIZE];
    bit done;
    lg = cur_log;
    if (lg < 1) lg = 1;
    if (lg > MAX_LOG_SIZE) lg = MAX_LOG_SIZE;
    side = 1 << lg;
    x = pos_x & (side - 1);
    y = pos_y & (side - 1);
    v = px;
    count = 0;
    done = 1'b0;
    for (l = 0; l < lg && !done; l++) begin
      sx = x >> l;
      sy = y >> l;
      if ((sx & 1) == 0) begin
        // even column waits for its right neighbour
        left_px[l] = v;
        done = 1'b1;
      end else begin
        pm = (left_px[l] < v) ? left_px[l] : v;
        idx = ((side - (side >> l)) + (sx >> 1)) & (LINE_DEPTH - 1);
        if ((sy & 1) == 0) begin
          // even row: park the pair minimum for the odd row
          line_mins[idx] = pm;
          done = 1'b1;
        end else begin
          v = (line_mins[idx] < pm) ? line_mins[idx] : pm;
          r.level     = LVL_W'(l + 1);
          r.col       = COORD_W'(sx >> 1);
          r.row       = COORD_W'(sy >> 1);
          r.min_value = v;
          r.last      = 1'b0;
          cascade[count] = r;
          count++;
        end
      end
    end
    for (l = 0; l < count; l++) begin
      r = cascade[l];
      r.last = (l == count - 1);
      expected_mins.push_back(r);
    end
    // raster advance with wrap at end of frame
    x++;
    if (x == side) begin
      x = 0;
      y++;
      if (y == side) y = 0;
    end
    pos_x = x;
    pos_y = y;
  endtask

  // result side: random stall and field compare
  always @(posedge clk) begin : check_results
    res_t exp_res;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_mins.size() == 0) begin
        $error("unexpected result beat: level %0d col %0d row %0d min_value %0d",
               out_level, out_col, out_row, out_min_value);
        failed = 1'b1;
      end else begin
        exp_res = expected_mins.pop_front();
        if (out_level !== exp_res.level) begin
          $error("level: expected %0d, actual %0d", exp_res.level, out_level);
          failed = 1'b1;
        end
        if (out_col !== exp_res.col) begin
          $error("col: expected %0d, actual %0d", exp_res.col, out_col);
          failed = 1'b1;
        end
        if (out_row !== exp_res.row) begin
          $error("row: expected %0d, actual %0d", exp_res.row, out_row);
          failed = 1'b1;
        end
        if (out_min_value !== exp_res.min_value) begin
          $error("min_value: expected %0d, actual %0d", exp_res.min_value, out_min_value);
          failed = 1'b1;
        end
        if (out_last !== exp_res.last) begin
          $error("last: expected %0d, actual %0d", exp_res.last, out_last);
          failed = 1'b1;
        end
      end
    end
    out_stall <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);
  end

  // one pixel beat; valid stays high unless a gap follows
  task automatic send_pixel(input logic [PIX_W-1:0] px);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_pixel <= px;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pyramid_predict(px);
    pixels_sent++;
  endtask

  function automatic logic [PIX_W-1:0] rand_pixel();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 15) return '0;
    if (pick < 30) return '1;
    return PIX_W'($urandom_range(255));
  endfunction

  task automatic send_random_pixels(input int unsigned n);
    int unsigned i;
    for (i = 0; i < n; i++) send_pixel(rand_pixel());
  endtask

  task automatic send_frame4(input logic [PIX_W-1:0] a, b, c, d);
    send_pixel(a);
    send_pixel(b);
    send_pixel(c);
    send_pixel(d);
  endtask

  // let every cascade and any trailing pixel work finish
  task automatic drain_block();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_mins.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // size write, only from idle; also restarts the frame
  task automatic write_log_size(input logic [LVL_W-1:0] val);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cur_log = val;
    pos_x = 0;
    pos_y = 0;
  endtask

  task automatic set_idling(input int unsigned ph);
    case (ph)
      0: begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      1: begin
        send_idle_pct  = 82;
        recv_stall_pct = 0;
      end
      2: begin
        send_idle_pct  = 0;
        recv_stall_pct = 82;
      end
      default: begin
        send_idle_pct  = 18;
        recv_stall_pct = 18;
      end
    endcase
  endtask

  // reset size is 256 wide, so a few pixels close no block
  task automatic test_reset_size();
    send_random_pixels(6);
    drain_block();
  endtask

  // 2x2 frames: extremes, minimum in each corner, frame wrap
  task automatic test_smallest_frame();
    write_log_size(LVL_W'(1));
    send_frame4(8'd255, 8'd255, 8'd255, 8'd255);
    send_frame4(8'd0, 8'd0, 8'd0, 8'd0);
    send_frame4(8'd3, 8'd250, 8'd251, 8'd252);
    send_frame4(8'd250, 8'd3, 8'd251, 8'd252);
    send_frame4(8'd250, 8'd251, 8'd3, 8'd252);
    send_frame4(8'd250, 8'd251, 8'd252, 8'd3);
    drain_block();
  endtask

  // size zero behaves as size one
  task automatic test_size_below_range();
    write_log_size(LVL_W'(0));
    send_frame4(8'd17, 8'd16, 8'd18, 8'd200);
    drain_block();
  endtask

  // size write in the middle of a frame starts a new one
  task automatic test_mid_frame_restart();
    write_log_size(LVL_W'(2));
    send_random_pixels(6);
    drain_block();
    write_log_size(LVL_W'(2));
    send_random_pixels(16);
    drain_block();
  endtask

  // largest side: clamp from 15, then the top size; first row only, no block closes
  task automatic test_largest_frame();
    set_idling(3);
    write_log_size(LVL_W'(15));
    send_random_pixels(12);
    drain_block();
    write_log_size(LVL_W'(MAX_LOG_SIZE));
    send_random_pixels(12);
    drain_block();
    set_idling(0);
  endtask

  // one random stretch: whole frames, partial frames or odd sizes
  task automatic random_episode(input int unsigned budget);
    int unsigned kind, lg, n;
    kind = $urandom_range(99);
    if (kind < 70) begin
      lg = ($urandom_range(99) < 5) ? 4 : $urandom_range(1, 3);
      if (lg != cur_log || $urandom_range(1) == 1) begin
        drain_block();
        write_log_size(LVL_W'(lg));
      end
      n = $urandom_range(1, 2) * (1 << (2 * lg));
    end else if (kind < 88) begin
      lg = $urandom_range(1, 4);
      drain_block();
      write_log_size(LVL_W'(lg));
      n = (lg == 4) ? $urandom_range(1, 40) : $urandom_range(1, (1 << (2 * lg)) - 1);
    end else begin
      drain_block();
      write_log_size(($urandom_range(1) == 1) ? LVL_W'(0) : LVL_W'($urandom_range(11, 15)));
      n = $urandom_range(1, 40);
    end
    if (n > budget) n = budget;
    send_random_pixels(n);
  endtask

  task automatic test_random_frames();
    int unsigned ph, start;
    for (ph = 0; ph < 4; ph++) begin
      set_idling(ph);
      start = pixels_sent;
      while (pixels_sent - start < RANDOM_ITEMS / 4) begin
        random_episode(RANDOM_ITEMS / 4 - (pixels_sent - start));
      end
    end
    set_idling(0);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_size();
    test_smallest_frame();
    test_size_below_range();
    test_mid_frame_restart();
    test_largest_frame();
    test_random_frames();
    drain_block();
    if (!failed) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl
rtl/mdp_pkg.sv
rtl/mdp_front.sv
rtl/mdp_cmd_q.sv
rtl/mdp_back.sv
rtl/mdp_res_q.sv
rtl/min_depth_pyramid_builder.sv
tb/tb_min_depth_pyramid_builder.sv
